/* sv/abtc_pkg.sv */
// Shared types for the ARP binding table check: command and status codes,
// table entry layout and the command record passed from queue to engine.
// No dependencies.
`timescale 1ns / 1ps

package abtc_pkg;

    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int SESS_W  = 16;
    localparam int USED_W  = 11;
    localparam int SPOOF_W = 32;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DEL_IP   = 2'd1,
        OP_DEL_SESS = 2'd2,
        OP_VALIDATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_PASS    = 3'd2,
        ST_SPOOF   = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [SESS_W-1:0] sess;
    } entry_t;

    typedef struct packed {
        op_t               op;
        logic              bypass;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [SESS_W-1:0] sess;
    } cmd_t;

endpackage

/* sv/arp_binding_table_check.sv */
// Top level of the ARP binding table check: command queue in front,
// scan engine with the binding memory behind it. Depends on abtc_pkg,
// abtc_cmd_queue and abtc_engine.
//
//   channel  direction  handshake       payload
//   command  in         push / full     op, ip_addr, mac_addr, session_num
//   result   out        empty / pop     status, entries_used, spoof_total
//   config   in         cfg_write       cfg_data (check_enable)
//
// For each command in the engine the memory read port visits every entry
// once, then the finish state writes back and loads the result. A validate
// with checking off skips the scan and goes straight to the finish state.
// After reset a clearing pass over every entry holds full high.
// The queue keeps taking up to two commands while the engine is busy or a
// result waits; the engine holds its last write-back until pop frees the
// result register.
`timescale 1ns / 1ps

module arp_binding_table_check #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic         cfg_data,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   op,
    input  logic [31:0]  ip_addr,
    input  logic [47:0]  mac_addr,
    input  logic [15:0]  session_num,
    output logic         empty,
    input  logic         pop,
    output logic [2:0]   status,
    output logic [10:0]  entries_used,
    output logic [31:0]  spoof_total
);

    logic           q_full;
    logic           q_valid;
    abtc_pkg::cmd_t q_cmd;
    logic           q_pop;
    logic           eng_clearing;

    assign full = q_full || eng_clearing;

    abtc_cmd_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .push        (push && !eng_clearing),
        .op          (op),
        .ip_addr     (ip_addr),
        .mac_addr    (mac_addr),
        .session_num (session_num),
        .full        (q_full),
        .cmd_valid   (q_valid),
        .cmd         (q_cmd),
        .cmd_pop     (q_pop)
    );

    abtc_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_cmd),
        .cmd_pop      (q_pop),
        .clearing     (eng_clearing),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .entries_used (entries_used),
        .spoof_total  (spoof_total)
    );

endmodule

/* sv/abtc_cmd_queue.sv */
// Front end: holds check_enable, classifies each incoming item and keeps
// it in a two-entry queue for the engine. Depends on abtc_pkg.
`timescale 1ns / 1ps

module abtc_cmd_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic                         cfg_data,
    input  logic                         push,
    input  logic [1:0]                   op,
    input  logic [abtc_pkg::IP_W-1:0]    ip_addr,
    input  logic [abtc_pkg::MAC_W-1:0]   mac_addr,
    input  logic [abtc_pkg::SESS_W-1:0]  session_num,
    output logic                         full,
    output logic                         cmd_valid,
    output abtc_pkg::cmd_t               cmd,
    input  logic                         cmd_pop
);

    logic           check_en_reg;
    abtc_pkg::cmd_t slot_reg [2];
    logic           wptr_reg;
    logic           rptr_reg;
    logic [1:0]     cnt_reg;
    abtc_pkg::cmd_t in_cmd;
    logic           do_push;
    logic           do_pop;

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // A validate with checking off needs no table scan.
    always_comb
    begin
        in_cmd.op     = abtc_pkg::op_t'(op);
        in_cmd.bypass = (abtc_pkg::op_t'(op) == abtc_pkg::OP_VALIDATE) && !check_en_reg;
        in_cmd.ip     = ip_addr;
        in_cmd.mac    = mac_addr;
        in_cmd.sess   = session_num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_en_reg <= 1'b1;
            wptr_reg     <= 1'b0;
            rptr_reg     <= 1'b0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (cfg_write)
                check_en_reg <= cfg_data;
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= in_cmd;
    end

endmodule

/* sv/abtc_engine.sv */
// Back end: binding memory, clearing pass after reset, one-entry-per-cycle
// scan of the table for each command, and the result register.
// Depends on abtc_pkg.
`timescale 1ns / 1ps

module abtc_engine #(
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  abtc_pkg::cmd_t                 cmd,
    output logic                           cmd_pop,
    output logic                           clearing,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     status,
    output logic [abtc_pkg::USED_W-1:0]    entries_used,
    output logic [abtc_pkg::SPOOF_W-1:0]   spoof_total
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR  = 4'b0001,
        S_IDLE   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } eng_state_t;

    abtc_pkg::entry_t mem [TABLE_ENTRIES];

    eng_state_t        state_reg, state_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic              issue_reg, issue_next;
    logic              dv_reg;
    logic [AW-1:0]     didx_reg;
    abtc_pkg::entry_t  rd_data_reg;
    abtc_pkg::cmd_t    cmd_reg, cmd_next;
    logic              found_reg, found_next;
    logic [AW-1:0]     found_idx_reg, found_idx_next;
    logic [abtc_pkg::MAC_W-1:0] found_mac_reg, found_mac_next;
    logic              free_reg, free_next;
    logic [AW-1:0]     free_idx_reg, free_idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [abtc_pkg::SPOOF_W-1:0] spoof_reg, spoof_next;
    logic              out_valid_reg, out_valid_next;
    abtc_pkg::status_t out_status_reg, out_status_next;
    logic [abtc_pkg::USED_W-1:0] out_count_reg, out_count_next;

    logic              issue;
    logic              rd_en;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    abtc_pkg::entry_t  wr_data;
    logic              hit_ip;
    logic              hit_sess;

    assign clearing     = (state_reg == S_CLEAR);
    assign empty        = !out_valid_reg;
    assign status       = out_status_reg;
    assign entries_used = out_count_reg;
    assign spoof_total  = spoof_reg;

    assign issue    = (state_reg == S_SCAN) && issue_reg;
    assign rd_en    = issue;
    assign hit_ip   = rd_data_reg.valid && (rd_data_reg.ip == cmd_reg.ip);
    assign hit_sess = rd_data_reg.valid && (rd_data_reg.sess == cmd_reg.sess);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        cmd_next        = cmd_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_mac_next  = found_mac_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        count_next      = count_reg;
        spoof_next      = spoof_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = addr_reg;
        wr_data         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == LAST)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    addr_next  = '0;
                    issue_next = 1'b1;
                    state_next = cmd.bypass ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    addr_next = addr_reg + AW'(1);
                    if (addr_reg == LAST)
                        issue_next = 1'b0;
                end
                if (dv_reg)
                begin
                    if (hit_ip && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_idx_next = didx_reg;
                        found_mac_next = rd_data_reg.mac;
                    end
                    if (!rd_data_reg.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = didx_reg;
                    end
                    // drop every binding of the session as the scan passes it
                    if ((cmd_reg.op == abtc_pkg::OP_DEL_SESS) && hit_sess)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = didx_reg;
                        count_next = count_reg - CW'(1);
                    end
                    if (didx_reg == LAST)
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (!out_valid_reg || pop)
                begin
                    out_status_next = abtc_pkg::ST_DONE;
                    case (cmd_reg.op)
                        abtc_pkg::OP_ADD:
                        begin
                            wr_data = '{valid: 1'b1, ip: cmd_reg.ip, mac: cmd_reg.mac,
                                        sess: cmd_reg.sess};
                            if (found_reg)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = found_idx_reg;
                            end
                            else if (free_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = free_idx_reg;
                                count_next = count_reg + CW'(1);
                            end
                            else
                                out_status_next = abtc_pkg::ST_FULL;
                        end
                        abtc_pkg::OP_DEL_IP:
                        begin
                            if (found_reg)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = found_idx_reg;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        abtc_pkg::OP_VALIDATE:
                        begin
                            if (cmd_reg.bypass)
                                out_status_next = abtc_pkg::ST_PASS;
                            else if (!found_reg)
                                out_status_next = abtc_pkg::ST_UNKNOWN;
                            else if (found_mac_reg == cmd_reg.mac)
                                out_status_next = abtc_pkg::ST_PASS;
                            else
                            begin
                                out_status_next = abtc_pkg::ST_SPOOF;
                                spoof_next      = spoof_reg + 32'd1;
                            end
                        end
                        default:
                        begin
                            out_status_next = abtc_pkg::ST_DONE;
                        end
                    endcase
                    out_count_next = abtc_pkg::USED_W'(count_next);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            count_reg     <= '0;
            spoof_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            issue_reg     <= issue_next;
            dv_reg        <= issue;
            found_reg     <= found_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            spoof_reg     <= spoof_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        didx_reg       <= addr_reg;
        cmd_reg        <= cmd_next;
        found_idx_reg  <= found_idx_next;
        found_mac_reg  <= found_mac_next;
        free_idx_reg   <= free_idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[addr_reg];
    end

endmodule

/* sv/abtc_checker.sv */
// Port-level checks for arp_binding_table_check, attached by bind.
// Depends on abtc_pkg.
`timescale 1ns / 1ps

module abtc_checker #(
    parameter int TABLE_ENTRIES = 1024
) (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [10:0] entries_used,
    input logic [31:0] spoof_total
);

    localparam logic [10:0] N11 = 11'(TABLE_ENTRIES);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(entries_used)
                              && $stable(spoof_total)))
        else $error("result changed while waiting");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == abtc_pkg::ST_FULL)) |-> (entries_used == N11))
        else $error("table full reported with free slots");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (TABLE_ENTRIES < 2048)) |-> (entries_used <= N11))
        else $error("entry count above table size");

endmodule

bind arp_binding_table_check abtc_checker #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
) u_abtc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .entries_used (entries_used),
    .spoof_total  (spoof_total)
);
